/* sv/hcta_pkg.sv */
// Package for the heat/cool thermostat with alarm.
// Holds the beat payload types, configuration types, mode codes and constants.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package hcta_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } mode_e;

  localparam int unsigned AddrWidth = 5;

  localparam logic [2:0] RegCeiling  = 3'd0;
  localparam logic [2:0] RegFloor    = 3'd1;
  localparam logic [2:0] RegHyst     = 3'd2;
  localparam logic [2:0] RegAlarmTol = 3'd3;
  localparam logic [2:0] RegCompDly  = 3'd4;
  localparam logic [2:0] RegPowerOn  = 3'd5;
  localparam logic [2:0] RegCtrlOn   = 3'd6;

  localparam logic signed [15:0] NoReadingBelow = -16'sd1600;
  localparam logic [15:0]        MsPerMin       = 16'd60000;

  typedef struct packed {
    logic signed [15:0] temp_sample;
    logic [31:0]        now_ms;
  } in_beat_t;

  typedef struct packed {
    logic       heat_on;
    logic       cool_on;
    logic [1:0] status;
    logic       alarm;
    logic       cooling_held;
    logic       no_reading;
  } out_beat_t;

  typedef struct packed {
    logic signed [10:0] ceiling_temp;
    logic signed [10:0] floor_temp;
    logic [7:0]         hysteresis;
    logic [8:0]         alarm_tolerance;
    logic [10:0]        compressor_delay_min;
    logic               power_on;
    logic               control_on;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/heat_cool_thermostat_with_alarm_unit.sv */
// Top level of the heat/cool thermostat with alarm.
// Instantiates hcta_cfg_regs and hcta_core; depends on hcta_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_data_i   (in_beat_t)
//   out      output     out_valid_o/out_ready_i out_data_o (out_beat_t)
//   cfg      input      APB psel/penable       paddr/pwdata/prdata
//
// Each beat is captured in the input register and moves on to the result
// register when that is empty or being read; one beat per cycle is sustained
// while out_ready_i holds; the compare and delay logic sits between them.
// A stalled result holds its register while one more beat waits at the input.
// Reset restores the register defaults, idle mode, zero stop time and no alarm.
`default_nettype none

module heat_cool_thermostat_with_alarm_unit
  import hcta_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_beat_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_beat_t                 out_data_o
);

  cfg_t cfg;

  hcta_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hcta_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* sv/hcta_cfg_regs.sv */
// Configuration register file with an APB-style slave port.
// Drives the settings struct used by the regulation core.
// Depends on hcta_pkg.
`default_nettype none

module hcta_cfg_regs
  import hcta_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output cfg_t                      cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ceiling_temp         <= 11'sd320;
      cfg_q.floor_temp           <= 11'sd288;
      cfg_q.hysteresis           <= 8'd8;
      cfg_q.alarm_tolerance      <= 9'd32;
      cfg_q.compressor_delay_min <= 11'd5;
      cfg_q.power_on             <= 1'b0;
      cfg_q.control_on           <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegCeiling:  cfg_q.ceiling_temp         <= pwdata[10:0];
        RegFloor:    cfg_q.floor_temp           <= pwdata[10:0];
        RegHyst:     cfg_q.hysteresis           <= pwdata[7:0];
        RegAlarmTol: cfg_q.alarm_tolerance      <= pwdata[8:0];
        RegCompDly:  cfg_q.compressor_delay_min <= pwdata[10:0];
        RegPowerOn:  cfg_q.power_on             <= pwdata[0];
        RegCtrlOn:   cfg_q.control_on           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCeiling:  prdata = {21'd0, cfg_q.ceiling_temp};
      RegFloor:    prdata = {21'd0, cfg_q.floor_temp};
      RegHyst:     prdata = {24'd0, cfg_q.hysteresis};
      RegAlarmTol: prdata = {23'd0, cfg_q.alarm_tolerance};
      RegCompDly:  prdata = {21'd0, cfg_q.compressor_delay_min};
      RegPowerOn:  prdata = {31'd0, cfg_q.power_on};
      RegCtrlOn:   prdata = {31'd0, cfg_q.control_on};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/hcta_core.sv */
// Regulation core: input register, one pass of mode, delay and alarm logic,
// and a result register, with the mode, cool-stop time and alarm state.
// Depends on hcta_pkg.
`default_nettype none

module hcta_core
  import hcta_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  in_beat_t  in_q;
  logic      in_valid_q;
  out_beat_t res_q, res_d;
  logic      res_valid_q;
  mode_e     mode_q, mode_d, mode_n;
  logic [31:0] stop_q, stop_d;
  logic      alarm_q, alarm_d;
  logic      advance;

  logic signed [17:0] t_x, ceil_x, floor_x, hys_x, tol_x;
  logic               invalid, alarm_calc, delay_ok, held;
  logic [31:0]        elapsed;
  logic [26:0]        delay_ms;

  assign advance     = in_valid_q & (~res_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  assign t_x     = 18'(in_q.temp_sample);
  assign ceil_x  = 18'(cfg_i.ceiling_temp);
  assign floor_x = 18'(cfg_i.floor_temp);
  assign hys_x   = $signed({10'd0, cfg_i.hysteresis});
  assign tol_x   = $signed({9'd0, cfg_i.alarm_tolerance});

  assign invalid    = in_q.temp_sample < NoReadingBelow;
  assign alarm_calc = (t_x > ceil_x + tol_x) || (t_x < floor_x - tol_x);
  assign delay_ms   = 27'(cfg_i.compressor_delay_min) * 27'(MsPerMin);
  assign elapsed    = in_q.now_ms - stop_q;
  assign delay_ok   = elapsed >= {5'd0, delay_ms};

  always_comb begin
    mode_n = mode_q;
    stop_d = stop_q;
    held   = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (t_x < floor_x) begin
          mode_n = MODE_HEAT;
        end else if (t_x > ceil_x) begin
          if (delay_ok) begin
            mode_n = MODE_COOL;
          end else begin
            held = 1'b1;
          end
        end
      end
      MODE_HEAT: begin
        if (t_x >= floor_x + hys_x) begin
          mode_n = MODE_IDLE;
        end
      end
      MODE_COOL: begin
        if (t_x <= ceil_x - hys_x) begin
          mode_n = MODE_IDLE;
          stop_d = in_q.now_ms;
        end
      end
      default: ;
    endcase

    mode_d  = mode_q;
    alarm_d = alarm_q;
    res_d   = '0;
    if (!cfg_i.power_on) begin
      mode_d = MODE_IDLE;
      stop_d = stop_q;
    end else if (invalid) begin
      res_d.no_reading = 1'b1;
      stop_d = stop_q;
      if (!cfg_i.control_on) begin
        mode_d = MODE_IDLE;
      end
    end else if (!cfg_i.control_on) begin
      mode_d  = MODE_IDLE;
      stop_d  = stop_q;
      alarm_d = alarm_calc;
    end else begin
      mode_d             = mode_n;
      alarm_d            = alarm_calc;
      res_d.cooling_held = held;
      res_d.heat_on      = (mode_n == MODE_HEAT);
      res_d.cool_on      = (mode_n == MODE_COOL);
      if (mode_n == MODE_HEAT || mode_n == MODE_COOL) begin
        res_d.status = mode_n;
      end
    end
    res_d.alarm = alarm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      stop_q      <= 32'd0;
      alarm_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        mode_q      <= mode_d;
        stop_q      <= stop_d;
        alarm_q     <= alarm_d;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for heat_cool_thermostat_with_alarm_unit.
// It mirrors the thermostat and alarm behavior, streams temperature samples under random
// stalls and compares every result beat; depends on hcta_pkg and the unit itself.

module tb;
  import hcta_pkg::*;

  localparam int          NoReadLimit = -1600;
  localparam logic [31:0] MsPerMinute = 32'd60000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_beat_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_beat_t            out_data_o;

  heat_cool_thermostat_with_alarm_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  logic signed [10:0] ceil_r = 11'sd320;
  logic signed [10:0] floor_r = 11'sd288;
  logic [7:0]         hyst_r = 8'd8;
  logic [8:0]         tol_r = 9'd32;
  logic [10:0]        comp_dly_r = 11'd5;
  logic               power_r = 1'b0;
  logic               ctrl_r = 1'b1;

  mode_e       mode_q = MODE_IDLE;
  logic [31:0] last_stop_q = '0;
  logic        alarm_q = 1'b0;

  in_beat_t  sample_q[$];
  out_beat_t switch_due_q[$];
  int        fail_count = 0;
  bit        no_idle = 1'b0;
  bit        in_taken = 1'b0;
  bit        out_taken = 1'b0;
  int        in_gap = 0;
  int        out_wait = 0;
  int        walk_t = 300;
  logic [31:0] clock_ms = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic alarm_hit(int t);
    return (t > int'(ceil_r) + int'(tol_r)) || (t < int'(floor_r) - int'(tol_r));
  endfunction

  function automatic out_beat_t thermo_predict(in_beat_t b);
    logic signed [15:0] t16;
    int t;
    logic [31:0] delay_ms;
    out_beat_t r;
    t16 = b.temp_sample;
    t = t16;
    r = '0;
    delay_ms = 32'(comp_dly_r) * MsPerMinute;
    if (!power_r) begin
      mode_q = MODE_IDLE;
    end else if (t < NoReadLimit) begin
      r.no_reading = 1'b1;
      if (!ctrl_r) mode_q = MODE_IDLE;
    end else if (!ctrl_r) begin
      mode_q = MODE_IDLE;
      alarm_q = alarm_hit(t);
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (t < int'(floor_r)) begin
            mode_q = MODE_HEAT;
          end else if (t > int'(ceil_r)) begin
            if (b.now_ms - last_stop_q >= delay_ms) mode_q = MODE_COOL;
            else r.cooling_held = 1'b1;
          end
        end
        MODE_HEAT: begin
          if (t >= int'(floor_r) + int'(hyst_r)) mode_q = MODE_IDLE;
        end
        MODE_COOL: begin
          if (t <= int'(ceil_r) - int'(hyst_r)) begin
            last_stop_q = b.now_ms;
            mode_q = MODE_IDLE;
          end
        end
        default: ;
      endcase
      r.status = mode_q;
      alarm_q = alarm_hit(t);
    end
    r.heat_on = (r.status == MODE_HEAT);
    r.cool_on = (r.status == MODE_COOL);
    r.alarm = alarm_q;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_beat_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      if (switch_due_q.size() == 0) begin
        $error("result beat with no sample pending");
        fail_count++;
      end else begin
        due = switch_due_q.pop_front();
        check_field("heat_on", due.heat_on, out_data_o.heat_on);
        check_field("cool_on", due.cool_on, out_data_o.cool_on);
        check_field("status", due.status, out_data_o.status);
        check_field("alarm", due.alarm, out_data_o.alarm);
        check_field("cooling_held", due.cooling_held, out_data_o.cooling_held);
        check_field("no_reading", due.no_reading, out_data_o.no_reading);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      switch_due_q.push_back(thermo_predict(in_data_i));
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    logic     nv;
    in_beat_t nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (in_taken) begin
      nv = 1'b0;
      in_taken = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (sample_q.size() > 0) begin
        nd = sample_q.pop_front();
        nv = 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 9);
      end
    end
    in_valid_i <= nv;
    in_data_i <= nd;
  end

  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait = no_idle ? 0 : $urandom_range(0, 9);
    end
    if (out_wait > 0) begin
      out_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic cfg_write(logic [2:0] idx, int val);
    logic [31:0] wdata;
    wdata = '0;
    case (idx)
      RegCeiling: begin
        wdata = 32'(val[10:0]);
        ceil_r = val[10:0];
      end
      RegFloor: begin
        wdata = 32'(val[10:0]);
        floor_r = val[10:0];
      end
      RegHyst: begin
        wdata = 32'(val[7:0]);
        hyst_r = val[7:0];
      end
      RegAlarmTol: begin
        wdata = 32'(val[8:0]);
        tol_r = val[8:0];
      end
      RegCompDly: begin
        wdata = 32'(val[10:0]);
        comp_dly_r = val[10:0];
      end
      RegPowerOn: begin
        wdata = 32'(val[0]);
        power_r = val[0];
      end
      RegCtrlOn: begin
        wdata = 32'(val[0]);
        ctrl_r = val[0];
      end
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || switch_due_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic push_sample(int temp, logic [31:0] now);
    in_beat_t b;
    b.temp_sample = 16'(temp);
    b.now_ms = now;
    sample_q.push_back(b);
  endtask

  function automatic int pick_value(int lo, int hi, int wide_lo, int wide_hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return wide_lo + int'($urandom_range(0, wide_hi - wide_lo));
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  task automatic gen_walk(int n);
    int k;
    int lo;
    int hi;
    int temp;
    for (k = 0; k < n; k++) begin
      lo = ((int'(floor_r) < int'(ceil_r)) ? int'(floor_r) : int'(ceil_r)) - int'(tol_r) - 64;
      hi = ((int'(floor_r) > int'(ceil_r)) ? int'(floor_r) : int'(ceil_r)) + int'(tol_r) + 64;
      case ($urandom_range(0, 19))
        0: temp = int'($urandom_range(0, 65535)) - 32768;
        1: temp = -1601 - int'($urandom_range(0, 31167));
        default: begin
          walk_t = walk_t + int'($urandom_range(0, 80)) - 40;
          if (walk_t < lo || walk_t > hi) walk_t = lo + int'($urandom_range(0, hi - lo));
          temp = walk_t;
        end
      endcase
      if ($urandom_range(0, 15) == 0) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 90000);
      push_sample(temp, clock_ms);
    end
  endtask

  initial begin
    int p;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_sample(0, 32'd0);
    push_sample(1000, 32'd10);
    push_sample(-2000, 32'd20);
    wait_drained();

    cfg_write(RegPowerOn, 1);
    push_sample(300, 32'd0);
    push_sample(-32768, 32'd1);
    push_sample(-1601, 32'd2);
    push_sample(-1600, 32'd3);
    push_sample(295, 32'd4);
    push_sample(296, 32'd5);
    push_sample(400, 32'd1000);
    push_sample(352, 32'd300000);
    push_sample(313, 32'd300001);
    push_sample(312, 32'd400000);
    push_sample(330, 32'd699999);
    push_sample(330, 32'd700000);
    push_sample(312, 32'hFFFF_FFF0);
    push_sample(321, 32'h0004_93D0);
    push_sample(0, 32'h0004_93D1);
    push_sample(32767, 32'h0004_93D2);
    push_sample(287, 32'h0004_93D3);
    wait_drained();
    cfg_write(RegCtrlOn, 0);
    push_sample(100, 32'd1);
    push_sample(-2000, 32'd2);
    wait_drained();
    cfg_write(RegCtrlOn, 1);
    push_sample(0, 32'd3);
    wait_drained();
    cfg_write(RegPowerOn, 0);
    push_sample(0, 32'd4);
    wait_drained();

    cfg_write(RegCeiling, 800);
    cfg_write(RegFloor, -320);
    cfg_write(RegHyst, 160);
    cfg_write(RegAlarmTol, 320);
    cfg_write(RegCompDly, 1440);
    cfg_write(RegPowerOn, 1);
    gen_walk(40);
    wait_drained();

    cfg_write(RegCeiling, -320);
    cfg_write(RegFloor, 800);
    cfg_write(RegHyst, 0);
    cfg_write(RegAlarmTol, 0);
    cfg_write(RegCompDly, 0);
    gen_walk(40);
    wait_drained();

    for (p = 0; p < 12; p++) begin
      cfg_write(RegCeiling, pick_value(-320, 800, -1024, 1023));
      cfg_write(RegFloor, pick_value(-320, 800, -1024, 1023));
      cfg_write(RegHyst, pick_value(0, 160, 0, 255));
      cfg_write(RegAlarmTol, pick_value(0, 320, 0, 511));
      cfg_write(RegCompDly, ($urandom_range(0, 3) == 0) ? pick_value(0, 1440, 0, 2047)
                                                        : int'($urandom_range(0, 10)));
      cfg_write(RegPowerOn, ($urandom_range(0, 9) != 0));
      cfg_write(RegCtrlOn, ($urandom_range(0, 4) != 0));
      no_idle = ($urandom_range(0, 3) == 0);
      gen_walk(85);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("heat_cool_thermostat_with_alarm_unit regression: pass");
    end else begin
      $display("heat_cool_thermostat_with_alarm_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("heat_cool_thermostat_with_alarm_unit regression: fail");
    $finish;
  end

endmodule
